// File: rtl/date_sorted_insert_table_defines.svh
// Assertion macros for the sorted date table RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DATE_SORTED_INSERT_TABLE_DEFINES_SVH
`define DATE_SORTED_INSERT_TABLE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DSIT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DSIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dsit_pkg.sv
// Shared types and constants for the sorted date table.
// No dependencies.
`default_nettype none

package dsit_pkg;

    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [4:0] DAY_MAX     = 5'd31;
    localparam int         QUEUE_DEPTH = 2;
    localparam int         KEY_W       = 9;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_BAD_MONTH = 3'd1,
        ST_BAD_DAY   = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LIST   = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        cmd_kind_t kind;
        status_t   status;
        entry_t    entry;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/dsit_front.sv
// Front end: accepts requests and classifies them into table commands.
// Depends on dsit_pkg.
`default_nettype none

module dsit_front
    import dsit_pkg::*;
(
    input  wire logic        start,
    input  wire logic        kind,
    input  wire logic [3:0]  month,
    input  wire logic [4:0]  day,
    input  wire logic [15:0] payload_tag,
    input  wire q_stat_t     q_stat,
    output logic             busy,
    output logic             push,
    output cmd_t             push_cmd
);

    // Hold off new requests while the queue is full
    assign busy = q_stat.full;
    assign push = start && !q_stat.full;

    // Classify: list, bad month, bad day, or insert candidate
    always_comb
    begin
        push_cmd.entry.month = month;
        push_cmd.entry.day   = day;
        push_cmd.entry.tag   = payload_tag;
        push_cmd.status      = ST_ACCEPTED;
        push_cmd.kind        = CMD_INSERT;
        if (kind)
        begin
            push_cmd.kind = CMD_LIST;
        end
        else if (month == 4'd0 || month > MONTH_MAX)
        begin
            push_cmd.kind   = CMD_REJECT;
            push_cmd.status = ST_BAD_MONTH;
        end
        else if (day == 5'd0 || day > DAY_MAX)
        begin
            push_cmd.kind   = CMD_REJECT;
            push_cmd.status = ST_BAD_DAY;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsit_queue.sv
// Short command queue between the front end and the table engine.
// Depends on dsit_pkg.
`default_nettype none

module dsit_queue
    import dsit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output q_stat_t   q_stat
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign pop_cmd      = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (fill_reg == '0);
    assign q_stat.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsit_back.sv
// Table engine: sorted row of entry cells, insert by parallel compare and
// shift, list by rotating the occupied cells past cell 0. Depends on dsit_pkg.
`default_nettype none

`include "date_sorted_insert_table_defines.svh"

module dsit_back
    import dsit_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    pop_cmd,
    input  wire q_stat_t q_stat,
    output logic         pop,
    output logic         strobe,
    output status_t      res_status,
    output entry_t       res_entry,
    output logic         res_last
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_LIST = 2'b10
    } back_state_t;

    back_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    entry_t        cell_reg  [CAPACITY];
    entry_t        cell_next [CAPACITY];
    logic          strobe_reg, strobe_next;
    status_t       status_reg, status_next;
    entry_t        out_reg, out_next;
    logic          last_reg, last_next;

    logic [CAPACITY-1:0] gtx;
    logic [KEY_W-1:0]    key_new;
    logic                do_insert;
    logic                do_rotate;
    logic                is_full;

    assign key_new = {pop_cmd.entry.month, pop_cmd.entry.day};
    assign is_full = (count_reg == CW'(CAPACITY));
    assign pop     = (state_reg == BK_IDLE) && !q_stat.empty;

    // Mark cells whose key is above the new key; free cells count as above
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CW'(i) < count_reg)
            begin
                gtx[i] = key_new < {cell_reg[i].month, cell_reg[i].day};
            end
            else
            begin
                gtx[i] = 1'b1;
            end
        end
    end

    // Sequence commands and build the next result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        strobe_next = 1'b0;
        status_next = ST_ACCEPTED;
        out_next    = '0;
        last_next   = 1'b1;
        do_insert   = 1'b0;
        do_rotate   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    strobe_next = 1'b1;
                    case (pop_cmd.kind)
                        CMD_REJECT:
                        begin
                            status_next = pop_cmd.status;
                        end
                        CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_ACCEPTED;
                                do_insert   = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                status_next = ST_ENTRY;
                                out_next    = cell_reg[0];
                                do_rotate   = 1'b1;
                                last_next   = (count_reg == CW'(1));
                                remain_next = count_reg - 1'b1;
                                if (count_reg != CW'(1))
                                begin
                                    state_next = BK_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_BAD_MONTH;
                        end
                    endcase
                end
            end
            BK_LIST:
            begin
                strobe_next = 1'b1;
                status_next = ST_ENTRY;
                out_next    = cell_reg[0];
                do_rotate   = 1'b1;
                last_next   = (remain_reg == CW'(1));
                remain_next = remain_reg - 1'b1;
                if (remain_reg == CW'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Shift cells up for an insert, rotate occupied cells for a list
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_insert && gtx[i])
            begin
                if (i == 0)
                begin
                    cell_next[i] = pop_cmd.entry;
                end
                else if (!gtx[i-1])
                begin
                    cell_next[i] = pop_cmd.entry;
                end
                else
                begin
                    cell_next[i] = cell_reg[i-1];
                end
            end
            else if (do_rotate && (CW'(i) < count_reg))
            begin
                if (CW'(i) == count_reg - 1'b1)
                begin
                    cell_next[i] = cell_reg[0];
                end
                else
                begin
                    cell_next[i] = cell_reg[(i + 1 < CAPACITY) ? i + 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold table contents and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        status_reg <= status_next;
        out_reg    <= out_next;
        last_reg   <= last_next;
    end

    assign strobe     = strobe_reg;
    assign res_status = status_reg;
    assign res_entry  = out_reg;
    assign res_last   = last_reg;

    `DSIT_ASSERT_SAME(a_last_ends_list, strobe_reg && last_reg, state_reg == BK_IDLE, "list did not end on last")
    `DSIT_ASSERT_SAME(a_list_has_rows, state_reg == BK_LIST, remain_reg != '0, "list state with nothing left")
    `DSIT_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `DSIT_ASSERT_SAME(a_accept_grows, strobe_reg && status_reg == ST_ACCEPTED, count_reg == $past(count_reg) + 1'b1, "accepted insert did not grow table")

endmodule

`default_nettype wire

// File: rtl/date_sorted_insert_table.sv
// Sorted date table. With the engine free, a request is written into the
// command queue, then the engine registers its result and raises the result
// strobe; a list gives one entry per cycle.
// Throughput: one insert per cycle while no list is running; a list holds the
// engine to its last entry. busy rises only while the two-entry queue is full.
// Reset empties the table and the queue; no clearing pass is needed.
`default_nettype none

module date_sorted_insert_table
    import dsit_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [3:0]  month,
    input  wire logic [4:0]  day,
    input  wire logic [15:0] payload_tag,
    output logic             strobe,
    output logic [2:0]       status,
    output logic [3:0]       out_month,
    output logic [4:0]       out_day,
    output logic [15:0]      out_tag,
    output logic             last
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    pop_cmd;
    status_t res_status;
    entry_t  res_entry;

    dsit_front u_front (
        .start       (start),
        .kind        (kind),
        .month       (month),
        .day         (day),
        .payload_tag (payload_tag),
        .q_stat      (q_stat),
        .busy        (busy),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    dsit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    dsit_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_cmd    (pop_cmd),
        .q_stat     (q_stat),
        .pop        (pop),
        .strobe     (strobe),
        .res_status (res_status),
        .res_entry  (res_entry),
        .res_last   (last)
    );

    assign status    = res_status;
    assign out_month = res_entry.month;
    assign out_day   = res_entry.day;
    assign out_tag   = res_entry.tag;

endmodule

`default_nettype wire

// File: dv/date_sorted_insert_table_tb.sv
// Testbench for the sorted date table: a directed table of requests, then random requests,
// checked against an in-bench model of the sorted table; typed rows are checked against their own status.
// Depends on dsit_pkg and date_sorted_insert_table.

module date_sorted_insert_table_tb;
    import dsit_pkg::*;

    localparam int   TABLE_DEPTH     = 32;
    localparam logic KIND_INSERT     = 1'b0;
    localparam logic KIND_LIST       = 1'b1;
    localparam int   DIRECTED_ROWS   = 18;
    localparam int   RANDOM_REQUESTS = 392;
    localparam int   DRAIN_CYCLES    = 12;
    localparam int   CYCLE_LIMIT     = 400000;

    typedef struct {
        status_t     status;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] tag;
        logic        last;
    } result_t;

    // One directed request; typed rows carry their single expected status.
    typedef struct {
        logic        kind;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] tag;
        logic        typed;
        status_t     status;
    } row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        kind        = 1'b0;
    logic [3:0]  month       = '0;
    logic [4:0]  day         = '0;
    logic [15:0] payload_tag = '0;
    logic        busy;
    logic        strobe;
    logic [2:0]  status;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [15:0] out_tag;
    logic        last;

    entry_t  date_table[$];
    result_t pending_results[$];
    int      error_count   = 0;
    int      results_seen  = 0;
    int      cycle_count   = 0;
    int      stored_count  = 0;
    int      refused_count = 0;
    int      list_count    = 0;
    bit      gaps_on       = 1'b1;

    row_t directed_rows[DIRECTED_ROWS] = '{
        '{KIND_LIST,   4'd0,  5'd0,  16'h0000, 1'b1, ST_EMPTY},
        '{KIND_INSERT, 4'd0,  5'd1,  16'h0000, 1'b1, ST_BAD_MONTH},
        '{KIND_INSERT, 4'd13, 5'd1,  16'h1234, 1'b1, ST_BAD_MONTH},
        '{KIND_INSERT, 4'd15, 5'd31, 16'hFFFF, 1'b1, ST_BAD_MONTH},
        '{KIND_INSERT, 4'd0,  5'd0,  16'hFFFF, 1'b1, ST_BAD_MONTH},
        '{KIND_INSERT, 4'd1,  5'd0,  16'h0001, 1'b1, ST_BAD_DAY},
        '{KIND_INSERT, 4'd12, 5'd0,  16'hFFFF, 1'b1, ST_BAD_DAY},
        '{KIND_INSERT, 4'd12, 5'd31, 16'hFFFF, 1'b1, ST_ACCEPTED},
        '{KIND_LIST,   4'd0,  5'd0,  16'h0000, 1'b0, ST_ACCEPTED},
        '{KIND_INSERT, 4'd1,  5'd1,  16'h0000, 1'b1, ST_ACCEPTED},
        '{KIND_INSERT, 4'd6,  5'd15, 16'h1111, 1'b1, ST_ACCEPTED},
        '{KIND_INSERT, 4'd6,  5'd15, 16'h2222, 1'b1, ST_ACCEPTED},
        '{KIND_INSERT, 4'd6,  5'd14, 16'h3333, 1'b1, ST_ACCEPTED},
        '{KIND_INSERT, 4'd6,  5'd16, 16'h4444, 1'b1, ST_ACCEPTED},
        '{KIND_INSERT, 4'd12, 5'd31, 16'h0001, 1'b1, ST_ACCEPTED},
        '{KIND_LIST,   4'd15, 5'd0,  16'hABCD, 1'b0, ST_ACCEPTED},
        '{KIND_INSERT, 4'd1,  5'd1,  16'h5A5A, 1'b1, ST_ACCEPTED},
        '{KIND_LIST,   4'd9,  5'd31, 16'hFFFF, 1'b0, ST_ACCEPTED}
    };

    date_sorted_insert_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .month       (month),
        .day         (day),
        .payload_tag (payload_tag),
        .strobe      (strobe),
        .status      (status),
        .out_month   (out_month),
        .out_day     (out_day),
        .out_tag     (out_tag),
        .last        (last)
    );

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_result(status_t st, entry_t e, logic is_last);
        result_t r;
        r.status = st;
        r.month  = e.month;
        r.day    = e.day;
        r.tag    = e.tag;
        r.last   = is_last;
        pending_results.push_back(r);
    endfunction

    // Update the table model with one request and queue the results it causes
    function automatic void model_table_request(logic k, logic [3:0] m, logic [4:0] d,
                                                logic [15:0] tag);
        entry_t blank;
        entry_t item;
        int     pos;
        blank      = '0;
        item.month = m;
        item.day   = d;
        item.tag   = tag;
        if (k == KIND_LIST)
        begin
            if (date_table.size() == 0)
                push_result(ST_EMPTY, blank, 1'b1);
            else
                foreach (date_table[i])
                    push_result(ST_ENTRY, date_table[i], i == date_table.size() - 1);
        end
        else if (m < 4'd1 || m > MONTH_MAX)
            push_result(ST_BAD_MONTH, blank, 1'b1);
        else if (d < 5'd1 || d > DAY_MAX)
            push_result(ST_BAD_DAY, blank, 1'b1);
        else if (date_table.size() >= TABLE_DEPTH)
            push_result(ST_FULL, blank, 1'b1);
        else
        begin
            // place after every entry with an equal or smaller key
            pos = date_table.size();
            for (int i = 0; i < date_table.size(); i++)
            begin
                if ({m, d} < {date_table[i].month, date_table[i].day})
                begin
                    pos = i;
                    break;
                end
            end
            date_table.insert(pos, item);
            push_result(ST_ACCEPTED, blank, 1'b1);
        end
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(logic k, logic [3:0] m, logic [4:0] d, logic [15:0] tag,
                                logic typed, status_t typed_status);
        int      base;
        result_t r;
        start       <= 1'b1;
        kind        <= k;
        month       <= m;
        day         <= d;
        payload_tag <= tag;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        base = pending_results.size();
        model_table_request(k, m, d, tag);
        // replace the model's answer with the typed one on directed rows
        if (typed)
        begin
            while (pending_results.size() > base)
                void'(pending_results.pop_back());
            r.status = typed_status;
            r.month  = '0;
            r.day    = '0;
            r.tag    = '0;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end
        if (k == KIND_LIST)
            list_count++;
        else if (pending_results[$].status == ST_ACCEPTED)
            stored_count++;
        else
            refused_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Drop start for a number of cycles, with junk on the fields
    task automatic idle_for(int n);
        if (n > 0)
        begin
            start       <= 1'b0;
            kind        <= 1'($urandom);
            month       <= 4'($urandom);
            day         <= 5'($urandom);
            payload_tag <= 16'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off new requests until every expected result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    // Build one random request: mostly good inserts, half with clustered keys, some lists, some noise
    task automatic send_random_request();
        int          r;
        logic        k;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [15:0] tag;
        r   = $urandom_range(0, 99);
        k   = KIND_INSERT;
        m   = 4'($urandom);
        d   = 5'($urandom);
        tag = 16'($urandom);
        if (r < 18)
            k = KIND_LIST;
        else if (r < 78)
        begin
            if ($urandom_range(0, 1))
            begin
                m = 4'($urandom_range(3, 4));
                d = 5'($urandom_range(9, 11));
            end
            else
            begin
                m = 4'($urandom_range(1, 12));
                d = 5'($urandom_range(1, 31));
            end
        end
        send_request(k, m, d, tag, 1'b0, ST_ACCEPTED);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Compare each result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display({"%0t: unexpected result: expected none, got status %0d",
                          " month %0d day %0d tag %0h last %0b"},
                         $time, status, out_month, out_day, out_tag, last);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",    16'(want.status), 16'(status));
                check_field("out_month", 16'(want.month),  16'(out_month));
                check_field("out_day",   16'(want.day),    16'(out_day));
                check_field("out_tag",   want.tag,         out_tag);
                check_field("last",      16'(want.last),   16'(last));
            end
        end
    end

    // Bound the run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive reset, the directed table, then random requests
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].kind, directed_rows[i].month, directed_rows[i].day,
                         directed_rows[i].tag, directed_rows[i].typed,
                         directed_rows[i].status);
            idle_for(pick_gap());
        end
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // alternate stretches with and without idling
            if (n % 60 == 0)
                gaps_on = (n % 120 == 0);
            if (n % 100 == 99)
                wait_drained();
            send_random_request();
            idle_for(pick_gap());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d stored, %0d refused, %0d lists.",
                 stored_count + refused_count + list_count, stored_count, refused_count,
                 list_count);
        $display("Checked %0d results; table ended with %0d of %0d entries.",
                 results_seen, date_table.size(), TABLE_DEPTH);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
